// ----- src/rec_pkg.sv -----
// Shared types and constants of the read extent coalescer.
// Used by every module of the block; depends on nothing.
package rec_pkg;

   localparam int OFFSET_BITS = 48;
   localparam int LENGTH_BITS = 32;
   localparam int GAP_BITS    = 32;
   localparam int MAX_SPLIT   = 32;
   localparam int SPLIT_BITS  = $clog2(MAX_SPLIT + 1);
   localparam int MAX_RESULTS = 64;
   localparam int COUNT_BITS  = $clog2(MAX_RESULTS + 1);
   localparam int STATUS_BITS = 2;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERLAP  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_TOO_MANY = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_GAP      = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_BYTES = 1'd1;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] request_offset;
      logic [LENGTH_BITS-1:0] request_bytes;
      logic [STATUS_BITS-1:0] status;
      logic                   batch_done;
      logic [OFFSET_BITS-1:0] wanted_total;
      logic [OFFSET_BITS-1:0] bridged_total;
   } result_type;

endpackage

// ----- src/read_extent_coalescer_core.sv -----
// Top level of the read extent coalescer: configuration registers,
// sequencer and output register. Depends on rec_pkg, rec_seq, rec_rsp_reg.
//
// Extents arrive in ascending offset order and are merged into runs that
// are sent out as read requests of at most target_bytes (whole runs when
// it is zero). One request is handled at a time: req_stall is high from
// acceptance until the sequencer has finished with it. The shared
// adder/subtractor in rec_seq sets the pace, and each result request is
// loaded only while the output register is free. The output register lets
// the next extent be taken while the last result is still waiting on the
// response side.
module read_extent_coalescer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rec_pkg::OFFSET_BITS-1:0]     req_extent_offset,
   input  logic [rec_pkg::LENGTH_BITS-1:0]     req_extent_bytes,
   input  logic                                req_batch_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rec_pkg::OFFSET_BITS-1:0]     rsp_request_offset,
   output logic [rec_pkg::LENGTH_BITS-1:0]     rsp_request_bytes,
   output logic [rec_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic                                rsp_batch_done,
   output logic [rec_pkg::OFFSET_BITS-1:0]     rsp_wanted_total,
   output logic [rec_pkg::OFFSET_BITS-1:0]     rsp_bridged_total,
   input  logic                                csr_write_en,
   input  logic [rec_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rec_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   logic [rec_pkg::GAP_BITS-1:0]    max_gap_ff, max_gap_in;
   logic [rec_pkg::LENGTH_BITS-1:0] target_ff, target_in;
   logic                            seq_idle;
   logic                            out_free;
   logic                            out_load;
   rec_pkg::result_type             out_data;

   always_comb begin
      max_gap_in = max_gap_ff;
      target_in  = target_ff;
      if (csr_write_en) begin
         priority if (csr_index == rec_pkg::CSR_MAX_GAP) begin
            max_gap_in = rec_pkg::GAP_BITS'(csr_wdata);
         end else if (csr_index == rec_pkg::CSR_TARGET_BYTES) begin
            target_in = rec_pkg::LENGTH_BITS'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff <= '0;
         target_ff  <= '0;
      end else begin
         max_gap_ff <= max_gap_in;
         target_ff  <= target_in;
      end
   end

   assign req_stall = !seq_idle;

   rec_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .max_gap      (max_gap_ff),
      .target_bytes (target_ff),
      .start        (req_valid && seq_idle),
      .in_offset    (req_extent_offset),
      .in_bytes     (req_extent_bytes),
      .in_batch_end (req_batch_end),
      .idle         (seq_idle),
      .out_free     (out_free),
      .out_load     (out_load),
      .out_data     (out_data)
   );

   rec_rsp_reg u_rsp (
      .clock              (clock),
      .reset              (reset),
      .load               (out_load),
      .load_data          (out_data),
      .free               (out_free),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_request_offset (rsp_request_offset),
      .rsp_request_bytes  (rsp_request_bytes),
      .rsp_status         (rsp_status),
      .rsp_batch_done     (rsp_batch_done),
      .rsp_wanted_total   (rsp_wanted_total),
      .rsp_bridged_total  (rsp_bridged_total)
   );

endmodule

// ----- src/rec_alu.sv -----
// Shared add/subtract unit of the coalescer sequencer.
// Depends on rec_pkg for the offset width.
module rec_alu (
   input  logic [rec_pkg::OFFSET_BITS-1:0] op_a,
   input  logic [rec_pkg::OFFSET_BITS-1:0] op_b,
   input  logic                            op_sub,
   output logic [rec_pkg::OFFSET_BITS:0]   result
);

   always_comb begin
      if (op_sub) begin
         result = {1'b0, op_a} - {1'b0, op_b};
      end else begin
         result = {1'b0, op_a} + {1'b0, op_b};
      end
   end

endmodule

// ----- src/rec_rsp_reg.sv -----
// Output register of the coalescer: holds one result request until taken.
// Depends on rec_pkg for result_type.
module rec_rsp_reg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  rec_pkg::result_type                 load_data,
   output logic                                free,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rec_pkg::OFFSET_BITS-1:0]     rsp_request_offset,
   output logic [rec_pkg::LENGTH_BITS-1:0]     rsp_request_bytes,
   output logic [rec_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic                                rsp_batch_done,
   output logic [rec_pkg::OFFSET_BITS-1:0]     rsp_wanted_total,
   output logic [rec_pkg::OFFSET_BITS-1:0]     rsp_bridged_total
);

   logic                valid_ff;
   logic                valid_in;
   rec_pkg::result_type data_ff;
   rec_pkg::result_type data_in;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      if (load && free) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_request_offset = data_ff.request_offset;
   assign rsp_request_bytes  = data_ff.request_bytes;
   assign rsp_status         = data_ff.status;
   assign rsp_batch_done     = data_ff.batch_done;
   assign rsp_wanted_total   = data_ff.wanted_total;
   assign rsp_bridged_total  = data_ff.bridged_total;

endmodule

// ----- src/rec_seq.sv -----
// Sequencer of the coalescer: run state, batch sums and chunk emission, with the offset,
// gap, run length and batch sum arithmetic through one shared rec_alu. Depends on rec_pkg, rec_alu.
module rec_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rec_pkg::GAP_BITS-1:0]        max_gap,
   input  logic [rec_pkg::LENGTH_BITS-1:0]     target_bytes,
   input  logic                                start,
   input  logic [rec_pkg::OFFSET_BITS-1:0]     in_offset,
   input  logic [rec_pkg::LENGTH_BITS-1:0]     in_bytes,
   input  logic                                in_batch_end,
   output logic                                idle,
   input  logic                                out_free,
   output logic                                out_load,
   output rec_pkg::result_type                 out_data
);

   localparam int OB = rec_pkg::OFFSET_BITS;
   localparam int LB = rec_pkg::LENGTH_BITS;
   localparam int CB = rec_pkg::COUNT_BITS;
   localparam int PB = LB + rec_pkg::SPLIT_BITS;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_D    = 4'd1;
   localparam logic [3:0] ST_G    = 4'd2;
   localparam logic [3:0] ST_S    = 4'd3;
   localparam logic [3:0] ST_BR   = 4'd4;
   localparam logic [3:0] ST_WANT = 4'd5;
   localparam logic [3:0] ST_NEW  = 4'd6;
   localparam logic [3:0] ST_FLAG = 4'd7;
   localparam logic [3:0] ST_EMIT = 4'd8;
   localparam logic [3:0] ST_BEND = 4'd9;
   localparam logic [3:0] ST_MARK = 4'd10;
   localparam logic [3:0] ST_FIN  = 4'd11;

   localparam logic [CB-1:0] N_LAST = CB'(rec_pkg::MAX_RESULTS - 1);
   localparam logic [CB-1:0] N_FULL = CB'(rec_pkg::MAX_RESULTS);

   logic [3:0]    state_ff, state_in;
   logic [OB-1:0] x_off_ff, x_off_in;
   logic [LB-1:0] x_len_ff, x_len_in;
   logic          x_bend_ff, x_bend_in;
   logic          run_open_ff, run_open_in;
   logic [OB-1:0] run_start_ff, run_start_in;
   logic [LB-1:0] run_len_ff, run_len_in;
   logic [OB-1:0] wanted_ff, wanted_in;
   logic [OB-1:0] bridged_ff, bridged_in;
   logic [OB-1:0] d_ff, d_in;
   logic [OB-1:0] g_ff, g_in;
   logic          lt_ff, lt_in;
   logic          emit_x_ff, emit_x_in;
   logic          phase_ff, phase_in;
   logic [OB-1:0] emit_off_ff, emit_off_in;
   logic [LB-1:0] emit_rem_ff, emit_rem_in;
   logic [LB-1:0] emit_cap_ff, emit_cap_in;
   logic [CB-1:0] n_ff, n_in;
   logic [rec_pkg::STATUS_BITS-1:0] flag_st_ff, flag_st_in;

   logic [OB-1:0] alu_a, alu_b;
   logic          alu_sub;
   logic [OB:0]   alu_res;

   logic [LB-1:0] take;
   logic          final_chunk;
   logic          merge;
   logic          too_many;
   logic [PB-1:0] split_limit;
   logic [LB-1:0] run_cap;

   rec_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .op_sub (alu_sub),
      .result (alu_res)
   );

   assign idle        = (state_ff == ST_IDLE);
   assign take        = (emit_rem_ff < emit_cap_ff) ? emit_rem_ff : emit_cap_ff;
   assign final_chunk = (emit_rem_ff <= emit_cap_ff);
   assign split_limit = PB'(target_bytes) * PB'(rec_pkg::MAX_SPLIT);
   assign too_many    = (target_bytes != '0) && (PB'(x_len_ff) > split_limit);
   assign run_cap     = (target_bytes == '0) ? run_len_ff : target_bytes;
   assign merge       = (g_ff <= OB'(max_gap)) && (d_ff <= OB'(target_bytes)) &&
                        (alu_res <= (OB + 1)'(target_bytes));

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_D: begin
            alu_a   = x_off_ff;
            alu_b   = run_start_ff;
            alu_sub = 1'b1;
         end
         ST_G: begin
            alu_a   = d_ff;
            alu_b   = OB'(run_len_ff);
            alu_sub = 1'b1;
         end
         ST_S: begin
            alu_a = d_ff;
            alu_b = OB'(x_len_ff);
         end
         ST_BR: begin
            alu_a = bridged_ff;
            alu_b = g_ff;
         end
         ST_WANT: begin
            alu_a = wanted_ff;
            alu_b = OB'(x_len_ff);
         end
         ST_EMIT: begin
            alu_a = emit_off_ff;
            alu_b = OB'(take);
         end
         default: begin
            alu_a   = '0;
            alu_b   = '0;
            alu_sub = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      x_off_in     = x_off_ff;
      x_len_in     = x_len_ff;
      x_bend_in    = x_bend_ff;
      run_open_in  = run_open_ff;
      run_start_in = run_start_ff;
      run_len_in   = run_len_ff;
      wanted_in    = wanted_ff;
      bridged_in   = bridged_ff;
      d_in         = d_ff;
      g_in         = g_ff;
      lt_in        = lt_ff;
      emit_x_in    = emit_x_ff;
      phase_in     = phase_ff;
      emit_off_in  = emit_off_ff;
      emit_rem_in  = emit_rem_ff;
      emit_cap_in  = emit_cap_ff;
      n_in         = n_ff;
      flag_st_in   = flag_st_ff;
      out_load     = 1'b0;
      out_data     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_off_in  = in_offset;
               x_len_in  = in_bytes;
               x_bend_in = in_batch_end;
               n_in      = '0;
               state_in  = ST_D;
            end
         end
         ST_D: begin
            d_in  = alu_res[OB-1:0];
            lt_in = alu_res[OB];
            if (x_len_ff == '0) begin
               state_in = ST_BEND;
            end else if (!run_open_ff) begin
               state_in = ST_NEW;
            end else begin
               state_in = ST_G;
            end
         end
         ST_G: begin
            g_in = alu_res[OB-1:0];
            if (lt_ff || alu_res[OB]) begin
               flag_st_in = rec_pkg::STATUS_OVERLAP;
               state_in   = ST_FLAG;
            end else begin
               state_in = ST_S;
            end
         end
         ST_S: begin
            if (merge) begin
               run_len_in = alu_res[LB-1:0];
               emit_x_in  = 1'b0;
               state_in   = ST_BR;
            end else begin
               state_in = ST_NEW;
            end
         end
         ST_BR: begin
            bridged_in = alu_res[OB-1:0];
            state_in   = ST_WANT;
         end
         ST_WANT: begin
            wanted_in = alu_res[OB-1:0];
            state_in  = emit_x_ff ? ST_EMIT : ST_BEND;
         end
         ST_NEW: begin
            if (too_many) begin
               flag_st_in = rec_pkg::STATUS_TOO_MANY;
               state_in   = ST_FLAG;
            end else begin
               emit_x_in    = run_open_ff;
               phase_in     = 1'b0;
               emit_off_in  = run_start_ff;
               emit_rem_in  = run_len_ff;
               emit_cap_in  = run_cap;
               run_open_in  = 1'b1;
               run_start_in = x_off_ff;
               run_len_in   = x_len_ff;
               state_in     = ST_WANT;
            end
         end
         ST_FLAG: begin
            if (out_free) begin
               out_load                = 1'b1;
               out_data.request_offset = x_off_ff;
               out_data.request_bytes  = x_len_ff;
               out_data.status         = flag_st_ff;
               out_data.batch_done     = x_bend_ff && !run_open_ff;
               if (x_bend_ff && !run_open_ff) begin
                  out_data.wanted_total  = wanted_ff;
                  out_data.bridged_total = bridged_ff;
               end
               n_in     = n_ff + CB'(1);
               state_in = ST_BEND;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load                = 1'b1;
               out_data.request_offset = emit_off_ff;
               out_data.request_bytes  = take;
               out_data.status         = rec_pkg::STATUS_OK;
               out_data.batch_done     = x_bend_ff &&
                                         ((n_ff == N_LAST) || (phase_ff && final_chunk));
               if (out_data.batch_done) begin
                  out_data.wanted_total  = wanted_ff;
                  out_data.bridged_total = bridged_ff;
               end
               emit_off_in = alu_res[OB-1:0];
               emit_rem_in = emit_rem_ff - take;
               n_in        = n_ff + CB'(1);
               if (final_chunk || (n_ff == N_LAST)) begin
                  state_in = phase_ff ? ST_FIN : ST_BEND;
               end
            end
         end
         ST_BEND: begin
            if (!x_bend_ff) begin
               state_in = ST_IDLE;
            end else if (run_open_ff && (n_ff < N_FULL)) begin
               phase_in    = 1'b1;
               emit_off_in = run_start_ff;
               emit_rem_in = run_len_ff;
               emit_cap_in = run_cap;
               state_in    = ST_EMIT;
            end else if (n_ff == '0) begin
               state_in = ST_MARK;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_MARK: begin
            if (out_free) begin
               out_load               = 1'b1;
               out_data.status        = rec_pkg::STATUS_OK;
               out_data.batch_done    = 1'b1;
               out_data.wanted_total  = wanted_ff;
               out_data.bridged_total = bridged_ff;
               state_in               = ST_FIN;
            end
         end
         ST_FIN: begin
            run_open_in  = 1'b0;
            run_start_in = '0;
            run_len_in   = '0;
            wanted_in    = '0;
            bridged_in   = '0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_open_ff  <= 1'b0;
         run_start_ff <= '0;
         run_len_ff   <= '0;
         wanted_ff    <= '0;
         bridged_ff   <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         run_open_ff  <= run_open_in;
         run_start_ff <= run_start_in;
         run_len_ff   <= run_len_in;
         wanted_ff    <= wanted_in;
         bridged_ff   <= bridged_in;
         n_ff         <= n_in;
      end
      x_off_ff    <= x_off_in;
      x_len_ff    <= x_len_in;
      x_bend_ff   <= x_bend_in;
      d_ff        <= d_in;
      g_ff        <= g_in;
      lt_ff       <= lt_in;
      emit_x_ff   <= emit_x_in;
      phase_ff    <= phase_in;
      emit_off_ff <= emit_off_in;
      emit_rem_ff <= emit_rem_in;
      emit_cap_ff <= emit_cap_in;
      flag_st_ff  <= flag_st_in;
   end

endmodule

// ----- verif/tb_read_extent_coalescer_core.sv -----
// Self-checking testbench for read_extent_coalescer_core: a directed table and then random
// extent streams under six register settings, each request checked against a local predictor
// or an expected request from the table. Depends on rec_pkg and the RTL of the block only.
module tb_read_extent_coalescer_core;

   typedef logic [rec_pkg::OFFSET_BITS-1:0] offset_type;
   typedef logic [rec_pkg::LENGTH_BITS-1:0] length_type;

   typedef enum logic [1:0] {ROW_EXTENT, ROW_CHECKED, ROW_CONFIG} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      offset_type          offset;
      length_type          bytes;
      logic                closes_batch;
      logic [rec_pkg::CSR_DATA_BITS-1:0] gap_limit;
      logic [rec_pkg::CSR_DATA_BITS-1:0] size_cap;
      rec_pkg::result_type want;
   } stim_row_type;

   localparam offset_type TOP_OFFSET = '1;
   localparam length_type TOP_LENGTH = '1;
   localparam logic [63:0] OFFSET_MASK = (64'd1 << rec_pkg::OFFSET_BITS) - 1;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   offset_type req_extent_offset;
   length_type req_extent_bytes;
   logic req_batch_end;
   logic rsp_valid;
   logic rsp_stall;
   offset_type rsp_request_offset;
   length_type rsp_request_bytes;
   logic [rec_pkg::STATUS_BITS-1:0] rsp_status;
   logic rsp_batch_done;
   offset_type rsp_wanted_total;
   offset_type rsp_bridged_total;
   logic csr_write_en;
   logic [rec_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [rec_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   // predictor state and register copies
   logic [63:0] gap_limit_q;
   logic [63:0] size_cap_q;
   logic        run_open_q;
   logic [63:0] run_start_q;
   logic [63:0] run_length_q;
   offset_type  wanted_sum_q;
   offset_type  bridged_sum_q;

   rec_pkg::result_type pending_requests[$];
   stim_row_type        plan[$];
   int unsigned fault_count;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   read_extent_coalescer_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_extent_offset  (req_extent_offset),
      .req_extent_bytes   (req_extent_bytes),
      .req_batch_end      (req_batch_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_request_offset (rsp_request_offset),
      .rsp_request_bytes  (rsp_request_bytes),
      .rsp_status         (rsp_status),
      .rsp_batch_done     (rsp_batch_done),
      .rsp_wanted_total   (rsp_wanted_total),
      .rsp_bridged_total  (rsp_bridged_total),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #6000000;
      $display("read_extent_coalescer_core regression: fail");
      $finish;
   end

   function automatic rec_pkg::result_type req_result(input offset_type offset,
                                                      input length_type bytes,
                                                      input logic [rec_pkg::STATUS_BITS-1:0] status,
                                                      input logic done, input offset_type wanted,
                                                      input offset_type bridged);
      rec_pkg::result_type r;
      r.request_offset = offset;
      r.request_bytes  = bytes;
      r.status         = status;
      r.batch_done     = done;
      r.wanted_total   = wanted;
      r.bridged_total  = bridged;
      return r;
   endfunction

   function automatic void add_result(ref rec_pkg::result_type q[$],
                                      input rec_pkg::result_type r);
      q.insert(q.size(), r);
   endfunction

   function automatic void add_row(input stim_row_type row);
      plan.insert(plan.size(), row);
   endfunction

   // cut the open run into chunks of at most size_cap (whole run when zero)
   function automatic void close_run(ref rec_pkg::result_type out[$]);
      logic [63:0] chunk_cap;
      logic [63:0] at;
      logic [63:0] rem;
      logic [63:0] take;
      chunk_cap = (size_cap_q == 0) ? run_length_q : size_cap_q;
      at = run_start_q;
      rem = run_length_q;
      while (rem != 0 && out.size() < rec_pkg::MAX_RESULTS) begin
         take = (rem < chunk_cap) ? rem : chunk_cap;
         add_result(out, req_result(at[rec_pkg::OFFSET_BITS-1:0],
                                    take[rec_pkg::LENGTH_BITS-1:0], rec_pkg::STATUS_OK,
                                    1'b0, '0, '0));
         at = (at + take) & OFFSET_MASK;
         rem = rem - take;
      end
   endfunction

   function automatic void coalesce_extent(input offset_type offset, input length_type bytes,
                                           input logic closes_batch,
                                           ref rec_pkg::result_type out[$]);
      logic [63:0] o;
      logic [63:0] l;
      logic [63:0] d;
      logic        merge;
      int          tail;
      o = {{(64-rec_pkg::OFFSET_BITS){1'b0}}, offset};
      l = {{(64-rec_pkg::LENGTH_BITS){1'b0}}, bytes};
      d = '0;
      merge = 1'b0;
      if (bytes != 0) begin
         if (run_open_q && (o < run_start_q || o - run_start_q < run_length_q)) begin
            add_result(out, req_result(offset, bytes, rec_pkg::STATUS_OVERLAP, 1'b0, '0, '0));
         end else begin
            if (run_open_q) begin
               d = o - run_start_q;
               merge = (d - run_length_q) <= gap_limit_q && d <= size_cap_q &&
                       d + l <= size_cap_q;
            end
            if (merge) begin
               bridged_sum_q = bridged_sum_q + offset_type'(d - run_length_q);
               run_length_q = d + l;
               wanted_sum_q = wanted_sum_q + offset_type'(l);
            end else if (size_cap_q != 0 && l > size_cap_q * rec_pkg::MAX_SPLIT) begin
               add_result(out, req_result(offset, bytes, rec_pkg::STATUS_TOO_MANY, 1'b0,
                                          '0, '0));
            end else begin
               if (run_open_q) close_run(out);
               run_open_q = 1'b1;
               run_start_q = o;
               run_length_q = l;
               wanted_sum_q = wanted_sum_q + offset_type'(l);
            end
         end
      end
      if (closes_batch) begin
         if (run_open_q) close_run(out);
         run_open_q = 1'b0;
         run_start_q = '0;
         run_length_q = '0;
         if (out.size() == 0)
            add_result(out, req_result('0, '0, rec_pkg::STATUS_OK, 1'b0, '0, '0));
         tail = out.size() - 1;
         out[tail].batch_done = 1'b1;
         out[tail].wanted_total = wanted_sum_q;
         out[tail].bridged_total = bridged_sum_q;
         wanted_sum_q = '0;
         bridged_sum_q = '0;
      end
   endfunction

   function automatic stim_row_type extent_row(input offset_type offset, input length_type bytes,
                                               input logic closes_batch);
      stim_row_type r;
      r.kind = ROW_EXTENT;
      r.offset = offset;
      r.bytes = bytes;
      r.closes_batch = closes_batch;
      r.gap_limit = '0;
      r.size_cap = '0;
      r.want = '0;
      return r;
   endfunction

   function automatic stim_row_type checked_row(input offset_type offset,
                                                input length_type bytes,
                                                input logic closes_batch,
                                                input rec_pkg::result_type want);
      stim_row_type r;
      r = extent_row(offset, bytes, closes_batch);
      r.kind = ROW_CHECKED;
      r.want = want;
      return r;
   endfunction

   function automatic stim_row_type config_row(input logic [rec_pkg::CSR_DATA_BITS-1:0] gap_limit,
                                               input logic [rec_pkg::CSR_DATA_BITS-1:0] size_cap);
      stim_row_type r;
      r = extent_row('0, '0, 1'b0);
      r.kind = ROW_CONFIG;
      r.gap_limit = gap_limit;
      r.size_cap = size_cap;
      return r;
   endfunction

   // lower valid and wait until every predicted request has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_requests.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic apply_config(input logic [rec_pkg::CSR_DATA_BITS-1:0] gap_limit,
                               input logic [rec_pkg::CSR_DATA_BITS-1:0] size_cap);
      csr_write_en <= 1'b1;
      csr_index <= rec_pkg::CSR_MAX_GAP;
      csr_wdata <= gap_limit;
      @(posedge clock);
      csr_index <= rec_pkg::CSR_TARGET_BYTES;
      csr_wdata <= size_cap;
      @(posedge clock);
      csr_write_en <= 1'b0;
      gap_limit_q = {32'd0, gap_limit};
      size_cap_q = {32'd0, size_cap};
   endtask

   task automatic send_extent(input offset_type offset, input length_type bytes,
                              input logic closes_batch, input logic typed,
                              input rec_pkg::result_type want);
      rec_pkg::result_type produced[$];
      int unsigned idle;
      idle = 0;
      while (idle < 20 && $urandom_range(0, 99) < send_idle_pct) idle++;
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_extent_offset <= offset;
      req_extent_bytes <= bytes;
      req_batch_end <= closes_batch;
      do @(posedge clock); while (req_stall);
      coalesce_extent(offset, bytes, closes_batch, produced);
      if (typed) add_result(pending_requests, want);
      else foreach (produced[i]) add_result(pending_requests, produced[i]);
   endtask

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      rec_pkg::result_type got;
      rec_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = req_result(rsp_request_offset, rsp_request_bytes, rsp_status, rsp_batch_done,
                          rsp_wanted_total, rsp_bridged_total);
         if (pending_requests.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display({"unexpected request: off %h bytes %h status %0d done %b",
                         " wanted %h bridged %h"},
                        got.request_offset, got.request_bytes, got.status, got.batch_done,
                        got.wanted_total, got.bridged_total);
         end else begin
            want = pending_requests.pop_front();
            if (got.request_offset !== want.request_offset ||
                got.request_bytes !== want.request_bytes || got.status !== want.status ||
                got.batch_done !== want.batch_done || got.wanted_total !== want.wanted_total ||
                got.bridged_total !== want.bridged_total) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("request mismatch at %0t", $time);
                  $display("  exp: off %h bytes %h status %0d done %b wanted %h bridged %h",
                           want.request_offset, want.request_bytes, want.status,
                           want.batch_done, want.wanted_total, want.bridged_total);
                  $display("  got: off %h bytes %h status %0d done %b wanted %h bridged %h",
                           got.request_offset, got.request_bytes, got.status,
                           got.batch_done, got.wanted_total, got.bridged_total);
               end
            end
         end
      end
   end

   initial begin
      logic [rec_pkg::CSR_DATA_BITS-1:0] phase_gap[6];
      logic [rec_pkg::CSR_DATA_BITS-1:0] phase_cap[6];
      logic [63:0] cursor;
      logic [63:0] gap;
      logic [63:0] span;
      logic [63:0] ceiling;
      logic [63:0] reach;
      offset_type  offset;
      length_type  bytes;
      logic        closes_batch;
      int unsigned pick;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_extent_offset <= '0;
      req_extent_bytes <= '0;
      req_batch_end <= 1'b0;
      csr_write_en <= 1'b0;
      csr_index <= rec_pkg::CSR_MAX_GAP;
      csr_wdata <= '0;
      fault_count = 0;
      send_idle_pct = 27;
      recv_idle_pct = 74;
      gap_limit_q = '0;
      size_cap_q = '0;
      run_open_q = 1'b0;
      run_start_q = '0;
      run_length_q = '0;
      wanted_sum_q = '0;
      bridged_sum_q = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset: no merge, no split
      add_row(checked_row('0, '0, 1'b1,
                          req_result('0, '0, rec_pkg::STATUS_OK, 1'b1, '0, '0)));
      add_row(extent_row(48'd123, '0, 1'b0));
      add_row(checked_row(TOP_OFFSET, TOP_LENGTH, 1'b1,
                          req_result(TOP_OFFSET, TOP_LENGTH, rec_pkg::STATUS_OK, 1'b1,
                                     48'hFFFF_FFFF, '0)));
      add_row(extent_row(48'd100, 32'd10, 1'b0));
      add_row(checked_row(48'd105, 32'd4, 1'b0,
                          req_result(48'd105, 32'd4, rec_pkg::STATUS_OVERLAP, 1'b0, '0, '0)));
      add_row(checked_row(48'd50, 32'd5, 1'b0,
                          req_result(48'd50, 32'd5, rec_pkg::STATUS_OVERLAP, 1'b0, '0, '0)));
      add_row(extent_row(48'd110, 32'd10, 1'b0));
      add_row(extent_row(48'd500, '0, 1'b1));
      // merge, split, too many chunks, wrap at the top of the offset space
      add_row(config_row(32'd8, 32'd16));
      add_row(extent_row(48'd1000, 32'd4, 1'b0));
      add_row(extent_row(48'd1006, 32'd6, 1'b0));
      add_row(extent_row(48'd1020, 32'd40, 1'b0));
      add_row(checked_row(48'd2000, 32'd513, 1'b0,
                          req_result(48'd2000, 32'd513, rec_pkg::STATUS_TOO_MANY, 1'b0,
                                     '0, '0)));
      add_row(extent_row(48'd2000, 32'd512, 1'b1));
      add_row(extent_row(TOP_OFFSET - 48'd19, 32'd40, 1'b1));
      add_row(config_row('1, '1));
      add_row(extent_row('0, TOP_LENGTH, 1'b0));
      add_row(extent_row(48'hFFFF_FFFF, 32'd1, 1'b0));
      add_row(extent_row(48'h1_0000_0100, 32'd16, 1'b1));
      add_row(config_row('0, 32'd1));
      add_row(extent_row(48'd10, 32'd32, 1'b1));
      add_row(checked_row(48'd10, 32'd33, 1'b1,
                          req_result(48'd10, 32'd33, rec_pkg::STATUS_TOO_MANY, 1'b1,
                                     '0, '0)));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CONFIG) begin
            settle();
            apply_config(plan[i].gap_limit, plan[i].size_cap);
         end else begin
            send_extent(plan[i].offset, plan[i].bytes, plan[i].closes_batch,
                        plan[i].kind == ROW_CHECKED, plan[i].want);
         end
      end

      phase_gap[0] = '1;       phase_cap[0] = '1;
      phase_gap[1] = 32'd64;   phase_cap[1] = 32'd4096;
      phase_gap[2] = '0;       phase_cap[2] = 32'd1;
      phase_gap[3] = 32'd16;   phase_cap[3] = 32'd100;
      phase_gap[4] = $urandom_range(0, 1000);
      phase_cap[4] = $urandom_range(1, 65535);
      phase_gap[5] = '0;       phase_cap[5] = '0;

      cursor = 64'($urandom_range(0, 1 << 20));
      for (int p = 0; p < 6; p++) begin
         settle();
         if (p < 2) begin
            send_idle_pct = 27;
            recv_idle_pct = 74;
         end else if (p < 4) begin
            send_idle_pct = 74;
            recv_idle_pct = 27;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         apply_config(phase_gap[p], phase_cap[p]);
         ceiling = (phase_cap[p] == 0) ? 64'd65536 : {32'd0, phase_cap[p]};
         reach = (phase_gap[p] < 64) ? {32'd0, phase_gap[p]} : 64'd64;
         for (int n = 0; n < 37; n++) begin
            if (n == 18) settle();
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: span = (ceiling < 4096) ? ceiling : 64'd4096;
                  5, 6, 7:       span = ceiling * 4;
                  8:             span = ceiling * rec_pkg::MAX_SPLIT;
                  default:       span = 64'hFFFF_FFFF;
               endcase
               if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
               bytes = $urandom_range(1, span[31:0]);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: gap = 64'($urandom_range(0, reach[31:0]));
                  6, 7:             gap = 64'd0;
                  default:          gap = 64'($urandom_range(0, 100000));
               endcase
               offset = offset_type'(cursor + gap);
               cursor = {16'd0, offset} + {32'd0, bytes};
            end else if (pick < 78) begin
               offset = offset_type'(cursor - $urandom_range(1, 32));
               bytes = $urandom_range(1, 64);
            end else if (pick < 86) begin
               offset = offset_type'({$urandom, $urandom});
               bytes = '0;
            end else if (pick < 92) begin
               offset = offset_type'(cursor);
               span = {32'd0, phase_cap[p]} * rec_pkg::MAX_SPLIT;
               if (phase_cap[p] != 0 && span < 64'hFFFF_FFFF)
                  bytes = $urandom_range(span[31:0] + 1, 32'hFFFF_FFFF);
               else
                  bytes = $urandom;
            end else begin
               offset = offset_type'({$urandom, $urandom});
               bytes = $urandom;
               if ({16'd0, offset} + {32'd0, bytes} > cursor)
                  cursor = {16'd0, offset} + {32'd0, bytes};
            end
            closes_batch = ($urandom_range(0, 7) == 0) || n == 36;
            send_extent(offset, bytes, closes_batch, 1'b0, '0);
            if (closes_batch) begin
               case ($urandom_range(0, 2))
                  0:       cursor = 64'($urandom_range(0, 1 << 20));
                  1:       cursor = {$urandom, $urandom} & OFFSET_MASK;
                  default: cursor = OFFSET_MASK + 1 - $urandom_range(1, 100000);
               endcase
            end
         end
      end

      settle();
      if (fault_count == 0 && pending_requests.size() == 0)
         $display("read_extent_coalescer_core regression: pass");
      else
         $display("read_extent_coalescer_core regression: fail");
      $finish;
   end

endmodule
